// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the HID report decoder.
// Standalone header; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication broken");

`endif

// ===== rtl/hidrd_pkg.sv =====
// Package for the HID input report decoder: constants, types, lookup functions.
// No dependencies; used by the front, queue, back and core RTL files of the block.
package hidrd_pkg;

    // Report kinds held in the kind register
    localparam logic [1:0] KIND_BITMASK  = 2'd0;
    localparam logic [1:0] KIND_KEYBOARD = 2'd1;
    localparam logic [1:0] KIND_CONSUMER = 2'd2;

    // Configuration register indexes
    localparam logic CFG_REPORT_KIND     = 1'b0;
    localparam logic CFG_ID_BYTE_PRESENT = 1'b1;

    // Button codes
    localparam logic [2:0] BTN_VOL_UP     = 3'd0;
    localparam logic [2:0] BTN_VOL_DOWN   = 3'd1;
    localparam logic [2:0] BTN_MUTE       = 3'd2;
    localparam logic [2:0] BTN_MIC_MUTE   = 3'd3;
    localparam logic [2:0] BTN_NEXT       = 3'd4;
    localparam logic [2:0] BTN_PREV       = 3'd5;
    localparam logic [2:0] BTN_STOP       = 3'd6;
    localparam logic [2:0] BTN_PLAY_PAUSE = 3'd7;

    // Boot keyboard keycodes
    localparam logic [7:0] KEY_SPACE = 8'h2C;
    localparam logic [7:0] KEY_RIGHT = 8'h4F;
    localparam logic [7:0] KEY_LEFT  = 8'h50;

    // Consumer usages
    localparam logic [15:0] USAGE_NEXT       = 16'h00B5;
    localparam logic [15:0] USAGE_PREV       = 16'h00B6;
    localparam logic [15:0] USAGE_STOP       = 16'h00B7;
    localparam logic [15:0] USAGE_PLAY_PAUSE = 16'h00CD;
    localparam logic [15:0] USAGE_MUTE       = 16'h00E2;
    localparam logic [15:0] USAGE_VOL_UP     = 16'h00E9;
    localparam logic [15:0] USAGE_VOL_DOWN   = 16'h00EA;

    localparam int NSLOTS     = 6;
    localparam int QDEPTH     = 2;
    localparam int MIN_KB_LEN = 8;

    typedef struct packed {
        logic       hit;
        logic [2:0] button;
    } map_t;

    // One decoded report: a slot mask and a button per slot, fired in slot order
    typedef struct packed {
        logic [NSLOTS-1:0]      mask;
        logic [NSLOTS-1:0][2:0] button;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qpush_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic map_t kb_map(input logic [7:0] code);
        map_t m;
        m = '0;
        unique case (code)
            KEY_SPACE: m = '{hit: 1'b1, button: BTN_PLAY_PAUSE};
            KEY_RIGHT: m = '{hit: 1'b1, button: BTN_NEXT};
            KEY_LEFT:  m = '{hit: 1'b1, button: BTN_PREV};
            default:   m = '0;
        endcase
        return m;
    endfunction

    function automatic map_t consumer_map(input logic [15:0] usage);
        map_t m;
        m = '0;
        unique case (usage)
            USAGE_NEXT:       m = '{hit: 1'b1, button: BTN_NEXT};
            USAGE_PREV:       m = '{hit: 1'b1, button: BTN_PREV};
            USAGE_STOP:       m = '{hit: 1'b1, button: BTN_STOP};
            USAGE_PLAY_PAUSE: m = '{hit: 1'b1, button: BTN_PLAY_PAUSE};
            USAGE_MUTE:       m = '{hit: 1'b1, button: BTN_MUTE};
            USAGE_VOL_UP:     m = '{hit: 1'b1, button: BTN_VOL_UP};
            USAGE_VOL_DOWN:   m = '{hit: 1'b1, button: BTN_VOL_DOWN};
            default:          m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/hidrd_report_if.sv =====
// Input channel of the HID report decoder: one report item per handshake.
// Stand-alone interface; no package needed.
interface hidrd_report_if;
    logic       valid;
    logic       ready;
    logic [6:0] report_length;
    logic [7:0] report_byte_0;
    logic [7:0] report_byte_1;
    logic [7:0] report_byte_2;
    logic [7:0] report_byte_3;
    logic [7:0] report_byte_4;
    logic [7:0] report_byte_5;
    logic [7:0] report_byte_6;
    logic [7:0] report_byte_7;

    modport source (
        output valid, report_length, report_byte_0, report_byte_1, report_byte_2,
               report_byte_3, report_byte_4, report_byte_5, report_byte_6, report_byte_7,
        input  ready
    );
    modport sink (
        input  valid, report_length, report_byte_0, report_byte_1, report_byte_2,
               report_byte_3, report_byte_4, report_byte_5, report_byte_6, report_byte_7,
        output ready
    );
endinterface

// ===== rtl/hidrd_press_if.sv =====
// Output channel of the HID report decoder: one press item per handshake.
// Stand-alone interface; no package needed.
interface hidrd_press_if;
    logic       valid;
    logic       ready;
    logic [2:0] button;
    logic       last_of_report;

    modport source (output valid, button, last_of_report, input ready);
    modport sink   (input valid, button, last_of_report, output ready);
endinterface

// ===== rtl/hidrd_front.sv =====
// Front end: config registers, held-key store and per-report classification.
// Depends on hidrd_pkg and hidrd_report_if.
module hidrd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    hidrd_report_if.sink         report,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [1:0]           cfg_wr_data,
    input  hidrd_pkg::qstat_t    qstat,
    output hidrd_pkg::qpush_t    qpush
);
    import hidrd_pkg::*;

    logic [1:0]              kind_reg;
    logic                    id_present_reg;
    logic [NSLOTS-1:0][7:0]  held_reg;
    logic [NSLOTS-1:0][7:0]  held_next;

    logic [7:0][7:0]         b;
    logic                    accept;
    logic                    len_zero;
    logic                    kb_long;
    logic                    cons_has_usage;
    logic                    cons_two;
    logic [15:0]             usage;
    map_t                    cons_hit;
    map_t [NSLOTS-1:0]       kb_hit;
    logic [NSLOTS-1:0]       kb_held;
    qentry_t                 entry;

    assign b = {report.report_byte_7, report.report_byte_6, report.report_byte_5,
                report.report_byte_4, report.report_byte_3, report.report_byte_2,
                report.report_byte_1, report.report_byte_0};

    assign report.ready = !qstat.full;
    assign accept       = report.valid && report.ready;
    assign len_zero     = (report.report_length == 7'd0);
    assign kb_long      = (report.report_length >= 7'(MIN_KB_LEN));

    // Consumer usage: skip optional ID, read one or two bytes
    assign cons_has_usage = (report.report_length > {6'd0, id_present_reg});
    assign cons_two       = id_present_reg ? (report.report_length >= 7'd3)
                                           : (report.report_length >= 7'd2);
    always_comb
    begin
        if (id_present_reg)
            usage = cons_two ? {b[2], b[1]} : {8'h00, b[1]};
        else
            usage = cons_two ? {b[1], b[0]} : {8'h00, b[0]};
    end
    assign cons_hit = consumer_map(usage);

    // Keyboard slots: new non-trivial code found in the key table
    always_comb
    begin
        for (int i = 0; i < NSLOTS; i++)
        begin
            kb_held[i] = 1'b0;
            for (int j = 0; j < NSLOTS; j++)
                kb_held[i] = kb_held[i] | (held_reg[j] == b[i+2]);
            kb_hit[i] = kb_map(b[i+2]);
        end
    end

    // Slot mask and buttons by mode
    always_comb
    begin
        entry = '0;
        if (!len_zero)
        begin
            unique case (kind_reg)
                KIND_KEYBOARD:
                begin
                    for (int i = 0; i < NSLOTS; i++)
                    begin
                        entry.mask[i]   = kb_long && (b[i+2] > 8'd1) && !kb_held[i]
                                          && kb_hit[i].hit;
                        entry.button[i] = kb_hit[i].button;
                    end
                end
                KIND_CONSUMER:
                begin
                    entry.mask[0]   = cons_has_usage && cons_hit.hit;
                    entry.button[0] = cons_hit.button;
                end
                default:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        entry.mask[i]   = b[0][i];
                        entry.button[i] = 3'(i);
                    end
                end
            endcase
        end
    end

    assign qpush.valid = accept && (entry.mask != '0);
    assign qpush.entry = entry;

    // Held-key store replaced by every accepted long keyboard report
    always_comb
    begin
        held_next = held_reg;
        if (accept && (kind_reg == KIND_KEYBOARD) && kb_long)
            for (int j = 0; j < NSLOTS; j++)
                held_next[j] = b[j+2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= KIND_BITMASK;
            id_present_reg <= 1'b0;
            held_reg       <= '0;
        end
        else
        begin
            held_reg <= held_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_REPORT_KIND:     kind_reg       <= cfg_wr_data;
                    CFG_ID_BYTE_PRESENT: id_present_reg <= cfg_wr_data[0];
                    default:             kind_reg       <= kind_reg;
                endcase
            end
        end
    end

endmodule

// ===== rtl/hidrd_queue.sv =====
// Short queue of decoded reports between the front and back ends.
// Depends on hidrd_pkg.
module hidrd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hidrd_pkg::qpush_t    qpush,
    input  logic                 pop,
    output hidrd_pkg::qentry_t   head,
    output hidrd_pkg::qstat_t    qstat
);
    import hidrd_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    qentry_t [QDEPTH-1:0] entries_reg;
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [PW:0]          count_reg;
    logic [PW:0]          count_next;
    logic                 do_push;
    logic                 do_pop;

    assign qstat.full  = (count_reg == (PW+1)'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = qpush.valid && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= qpush.entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

// ===== rtl/hidrd_back.sv =====
// Back end: walks the slot mask of the head report, one press item per cycle while the receiver is ready.
// Depends on hidrd_pkg and hidrd_press_if.
module hidrd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hidrd_pkg::qentry_t   head,
    input  hidrd_pkg::qstat_t    qstat,
    output logic                 pop,
    hidrd_press_if.source        press
);
    import hidrd_pkg::*;

    logic [NSLOTS-1:0] done_reg;
    logic [NSLOTS-1:0] done_next;
    logic              valid_reg;
    logic              valid_next;
    logic [2:0]        button_reg;
    logic              last_reg;

    logic [NSLOTS-1:0] remaining;
    logic [NSLOTS-1:0] pick;
    logic [2:0]        sel;
    logic              last;
    logic              advance;

    // Lowest pending slot
    assign remaining = head.mask & ~done_reg;
    assign pick      = remaining & (~remaining + 1'b1);
    assign last      = ((remaining & ~pick) == '0);
    assign advance   = !qstat.empty && (!valid_reg || press.ready);
    assign pop       = advance && last;

    always_comb
    begin
        sel = '0;
        for (int i = 0; i < NSLOTS; i++)
            if (pick[i])
                sel = 3'(i);
    end

    always_comb
    begin
        done_next  = done_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            done_next  = last ? '0 : (done_reg | pick);
        end
        else if (press.ready)
            valid_next = 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            button_reg <= head.button[sel];
            last_reg   <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    assign press.valid          = valid_reg;
    assign press.button         = button_reg;
    assign press.last_of_report = last_reg;

endmodule

// ===== rtl/hid_input_report_decoder_core.sv =====
// HID input report decoder: report channel in, press channel out.
// The report channel carries a length and the first eight bytes of one HID
// input report; the press channel carries one button item per decoded press,
// with last_of_report set on the final press of that report.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wr_data) set the report
// kind (index 0) and whether consumer reports carry an ID byte (index 1);
// write them only while the block is idle.
// Flow: an accepted report is written into the queue, and the back end then
// moves its first press into the output register. Presses leave one per
// cycle while the receiver is ready, from the single serialising back end.
// Reports are taken every cycle while the two-entry queue between front and
// back has room; reports that cause no press never enter the queue.
// Reset clears the configuration to bitmask mode without ID byte, empties the
// queue and output register, and clears the held-key store to all zero.
// When the receiver stalls, the press item holds; the queue then fills and
// report ready drops until space frees.
// Depends on hidrd_pkg, both channel interfaces, hidrd_front, hidrd_queue,
// hidrd_back and assert_macros.svh.
`include "assert_macros.svh"

module hid_input_report_decoder_core (
    input  logic          clk,
    input  logic          rst_n,
    hidrd_report_if.sink  report,
    hidrd_press_if.source press,
    input  logic          cfg_wr_en,
    input  logic          cfg_index,
    input  logic [1:0]    cfg_wr_data
);
    import hidrd_pkg::*;

    qpush_t  qpush;
    qstat_t  qstat;
    qentry_t head;
    logic    pop;

    hidrd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .report      (report),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .qstat       (qstat),
        .qpush       (qpush)
    );

    hidrd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qpush (qpush),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    hidrd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .press (press)
    );

    // Front never writes a full queue, back never pops an empty one
    `ASSERT_NEVER(a_push_when_full, clk, rst_n, qpush.valid && qstat.full)
    `ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && qstat.empty)
    // Queued entries always hold at least one press
    `ASSERT_NEVER(a_empty_mask, clk, rst_n, !qstat.empty && (head.mask == '0))
    // Nothing queued and nothing held: no press item next cycle
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, qstat.empty && !press.valid, !press.valid)

endmodule

// ===== bench/hidrd_press_checker.sv =====
`timescale 1ns / 100ps
// Press checker for the HID report decoder: watches both channels and the register port.
// It predicts the press items of each accepted report and compares them in order.
// Depends on hidrd_pkg and the two channel interfaces.
module hidrd_press_checker (
    input  logic    clk,
    input  logic    rst_n,
    hidrd_report_if report,
    hidrd_press_if  press,
    input  logic    cfg_wr_en,
    input  logic    cfg_index,
    input  logic [1:0] cfg_wr_data,
    output int      presses_pending,
    output int      fail_count
);
    import hidrd_pkg::*;

    localparam int HELD_DEPTH = 6;

    typedef struct packed {
        logic [2:0] button;
        logic       last;
    } press_t;

    // Mirror of the block's registers and held-key store
    logic [1:0] kind_reg;
    logic       id_present;
    logic [7:0] held_keys [HELD_DEPTH];

    press_t expected_presses [$];
    press_t want;
    logic   bad_button;
    logic   bad_last;

    // Work out the presses one report causes and queue them
    function automatic void decode_report(input logic [6:0] len, input logic [7:0][7:0] rb);
        logic [2:0]  found [$];
        logic [7:0]  code;
        logic [15:0] usage;
        logic        held;
        int          off;
        int          i;
        int          j;
        if (len == 7'd0)
            return;
        if (kind_reg == KIND_KEYBOARD)
        begin
            // short reports neither fire nor touch the store
            if (len < 7'd8)
                return;
            for (i = 2; i < 8; i++)
            begin
                code = rb[i];
                held = 1'b0;
                for (j = 0; j < HELD_DEPTH; j++)
                    if (held_keys[j] == code)
                        held = 1'b1;
                if (code > 8'h01 && !held)
                begin
                    case (code)
                        KEY_SPACE: found.push_back(BTN_PLAY_PAUSE);
                        KEY_RIGHT: found.push_back(BTN_NEXT);
                        KEY_LEFT:  found.push_back(BTN_PREV);
                        default:   ;
                    endcase
                end
            end
            for (j = 0; j < HELD_DEPTH; j++)
                held_keys[j] = rb[2 + j];
        end
        else if (kind_reg == KIND_CONSUMER)
        begin
            off = id_present ? 1 : 0;
            if (len <= off)
                return;
            // one byte past the ID is a usage on its own
            if (len - off >= 2)
                usage = {rb[off + 1], rb[off]};
            else
                usage = {8'h00, rb[off]};
            case (usage)
                USAGE_NEXT:       found.push_back(BTN_NEXT);
                USAGE_PREV:       found.push_back(BTN_PREV);
                USAGE_STOP:       found.push_back(BTN_STOP);
                USAGE_PLAY_PAUSE: found.push_back(BTN_PLAY_PAUSE);
                USAGE_MUTE:       found.push_back(BTN_MUTE);
                USAGE_VOL_UP:     found.push_back(BTN_VOL_UP);
                USAGE_VOL_DOWN:   found.push_back(BTN_VOL_DOWN);
                default:          ;
            endcase
        end
        else
        begin
            // bitmask remote; the unused kind lands here too
            if (rb[0][0])
                found.push_back(BTN_VOL_UP);
            if (rb[0][1])
                found.push_back(BTN_VOL_DOWN);
            if (rb[0][2])
                found.push_back(BTN_MUTE);
            if (rb[0][3])
                found.push_back(BTN_MIC_MUTE);
        end
        for (i = 0; i < found.size(); i++)
            expected_presses.push_back('{button: found[i], last: (i == found.size() - 1)});
    endfunction

    // Track registers, compare press items, predict from report items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   = KIND_BITMASK;
            id_present = 1'b0;
            for (int k = 0; k < HELD_DEPTH; k++)
                held_keys[k] = 8'h00;
            expected_presses.delete();
            fail_count = 0;
            presses_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_REPORT_KIND)
                    kind_reg = cfg_wr_data;
                else
                    id_present = cfg_wr_data[0];
            end

            // a press leaving now cannot come from a report taken at this edge
            if (press.valid && press.ready)
            begin
                if (expected_presses.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected press item: button %0d last %0b",
                                 $realtime, press.button, press.last_of_report);
                end
                else
                begin
                    want       = expected_presses.pop_front();
                    bad_button = (press.button !== want.button);
                    bad_last   = (press.last_of_report !== want.last);
                    if (bad_button || bad_last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: press mismatch: expected button %0d last %0b, got button %0d last %0b",
                                     $realtime, want.button, want.last,
                                     press.button, press.last_of_report);
                    end
                end
            end

            if (report.valid && report.ready)
                decode_report(report.report_length,
                              {report.report_byte_7, report.report_byte_6,
                               report.report_byte_5, report.report_byte_4,
                               report.report_byte_3, report.report_byte_2,
                               report.report_byte_1, report.report_byte_0});

            presses_pending <= expected_presses.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Bench top for the HID report decoder: clock, reset, register writes, report items and
// random stalls on both channels; the checker beside the core gives the failure count.
// Depends on hidrd_pkg, the channel interfaces, the core and hidrd_press_checker.
module tb;
    import hidrd_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [1:0] cfg_wr_data;
    logic       calm;
    int         cycles = 0;
    int         presses_pending;
    int         fail_count;

    hidrd_report_if report_ch ();
    hidrd_press_if  press_ch ();

    hid_input_report_decoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .report      (report_ch),
        .press       (press_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    hidrd_press_checker press_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .report          (report_ch),
        .press           (press_ch),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .presses_pending (presses_pending),
        .fail_count      (fail_count)
    );

    always #6 clk = ~clk;

    // Runaway guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one report item and hold it until taken; maybe leave a gap afterwards
    task automatic send_report(input logic [6:0] len, input logic [63:0] rb);
        report_ch.valid         <= 1'b1;
        report_ch.report_length <= len;
        report_ch.report_byte_0 <= rb[7:0];
        report_ch.report_byte_1 <= rb[15:8];
        report_ch.report_byte_2 <= rb[23:16];
        report_ch.report_byte_3 <= rb[31:24];
        report_ch.report_byte_4 <= rb[39:32];
        report_ch.report_byte_5 <= rb[47:40];
        report_ch.report_byte_6 <= rb[55:48];
        report_ch.report_byte_7 <= rb[63:56];
        do
            @(posedge clk);
        while (!report_ch.ready);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            report_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Drain all outstanding presses, then give the front end time to settle
    task automatic wait_idle();
        report_ch.valid <= 1'b0;
        @(posedge clk);
        while (presses_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers on consecutive edges
    task automatic set_mode(input logic [1:0] kind, input logic id_byte);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_REPORT_KIND;
        cfg_wr_data <= kind;
        @(posedge clk);
        cfg_index   <= CFG_ID_BYTE_PRESENT;
        cfg_wr_data <= {1'b0, id_byte};
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly the typical span, now and then empty or 64 and above
    function automatic logic [6:0] pick_length(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 7'd0;
        if (r == 1)
            return 7'($urandom_range(64, 127));
        return 7'($urandom_range(lo, hi));
    endfunction

    // Small pool so codes repeat across reports and get held
    function automatic logic [7:0] pick_keycode();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return KEY_SPACE;
            3:       return KEY_RIGHT;
            4:       return KEY_LEFT;
            5, 6:    return 8'(8'h04 + $urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_usage_low();
        case ($urandom_range(0, 9))
            0:       return USAGE_NEXT[7:0];
            1:       return USAGE_PREV[7:0];
            2:       return USAGE_STOP[7:0];
            3:       return USAGE_PLAY_PAUSE[7:0];
            4:       return USAGE_MUTE[7:0];
            5:       return USAGE_VOL_UP[7:0];
            6:       return USAGE_VOL_DOWN[7:0];
            7:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_report(input logic [1:0] kind, input logic id_byte);
        logic [6:0]      len;
        logic [7:0][7:0] rb;
        int              off;
        int              i;
        rb  = {$urandom, $urandom};
        off = id_byte ? 1 : 0;
        if (kind == KIND_KEYBOARD)
        begin
            if ($urandom_range(0, 9) == 0)
                len = 7'($urandom_range(1, 7));
            else
                len = pick_length(8, 12);
            for (i = 2; i < 8; i++)
                rb[i] = pick_keycode();
        end
        else if (kind == KIND_CONSUMER)
        begin
            len     = pick_length(1, 8);
            rb[off] = pick_usage_low();
            if ($urandom_range(0, 4) != 0)
                rb[off + 1] = 8'h00;
        end
        else
            len = pick_length(1, 8);
        send_report(len, rb);
    endtask

    task automatic run_phase(input logic [1:0] kind, input logic id_byte, input int count);
        wait_idle();
        set_mode(kind, id_byte);
        repeat (count)
            send_random_report(kind, id_byte);
    endtask

    // Receiver: runs of ready with random stall bursts
    initial
    begin
        press_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            press_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                press_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        calm = 1'b0;
        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_index               <= CFG_REPORT_KIND;
        cfg_wr_data             <= 2'b00;
        report_ch.valid         <= 1'b0;
        report_ch.report_length <= 7'd0;
        report_ch.report_byte_0 <= 8'h00;
        report_ch.report_byte_1 <= 8'h00;
        report_ch.report_byte_2 <= 8'h00;
        report_ch.report_byte_3 <= 8'h00;
        report_ch.report_byte_4 <= 8'h00;
        report_ch.report_byte_5 <= 8'h00;
        report_ch.report_byte_6 <= 8'h00;
        report_ch.report_byte_7 <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes below read 7 down to 0, byte 0 rightmost
        // bitmask remote, from reset: empty, all four, high bits only, long report
        send_report(7'd0,   64'hFFFF_FFFF_FFFF_FFFF);
        send_report(7'd1,   64'h0000_0000_0000_000F);
        send_report(7'd64,  64'hA5A5_A5A5_A5A5_A5F0);
        send_report(7'd127, 64'h0000_0000_0000_0005);

        // boot keyboard: short report leaves the store, then duplicates and held keys
        wait_idle();
        set_mode(KIND_KEYBOARD, 1'b0);
        send_report(7'd7,   64'h2C01_0050_4F2C_0000);
        send_report(7'd8,   64'h2C01_0050_4F2C_0000);
        send_report(7'd8,   64'h2C01_0050_4F2C_0000);
        send_report(7'd8,   64'h0000_0000_FF4F_FFFF);
        send_report(7'd8,   64'h502C_5050_2C2C_0000);
        send_report(7'd127, 64'h4F7F_8001_2C4F_0000);
        send_report(7'd0,   64'h0000_0000_2C2C_0000);

        // consumer, no ID: two-byte, lone byte, release, unknown usage, long report
        wait_idle();
        set_mode(KIND_CONSUMER, 1'b0);
        send_report(7'd2,   64'h0000_0000_0000_00B5);
        send_report(7'd1,   64'h0000_0000_0000_E9CD);
        send_report(7'd2,   64'hFFFF_FFFF_FFFF_0000);
        send_report(7'd3,   64'h0000_0000_0000_01E9);
        send_report(7'd64,  64'h0000_0000_0000_00EA);

        // consumer with ID byte: nothing past the ID, lone usage byte, table hits
        wait_idle();
        set_mode(KIND_CONSUMER, 1'b1);
        send_report(7'd1,   64'h0000_0000_0000_B5B5);
        send_report(7'd2,   64'h0000_0000_0000_B701);
        send_report(7'd3,   64'h0000_0000_0000_E201);
        send_report(7'd127, 64'h0000_0000_0000_B603);
        send_report(7'd8,   64'h0000_0000_0001_B701);

        // unused kind falls back to bitmask
        wait_idle();
        set_mode(KIND_UNUSED, 1'b0);
        send_report(7'd1,   64'h0000_0000_0000_000A);

        // random phases over several settings
        run_phase(KIND_BITMASK,  1'b1, 60);
        run_phase(KIND_KEYBOARD, 1'b0, 110);
        run_phase(KIND_CONSUMER, 1'b0, 70);
        run_phase(KIND_CONSUMER, 1'b1, 70);
        run_phase(KIND_UNUSED,   1'b0, 30);
        calm = 1'b1;
        run_phase(KIND_KEYBOARD, 1'b1, 80);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && presses_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hidrd_pkg.sv
rtl/hidrd_report_if.sv
rtl/hidrd_press_if.sv
rtl/hidrd_front.sv
rtl/hidrd_queue.sv
rtl/hidrd_back.sv
rtl/hid_input_report_decoder_core.sv
bench/hidrd_press_checker.sv
bench/tb.sv
